[rtl/cdc_pkg.sv]
// Shared types and calendar helpers for the calendar date counter.
// Holds the date record, the leap-year rule and the month length table.
// No dependencies.
package cdc_pkg;

    localparam logic [11:0] YEAR_TOP     = 12'd4095;
    localparam logic [11:0] YEAR_MIN_SET = 12'd1900;
    localparam logic [11:0] YEAR_MAX_SET = 12'd2100;
    localparam logic [4:0]  MOD25_LAST   = 5'd24;

    // The date as held by the counter. The year modulo 25 travels with the
    // year so that the leap rule needs no division.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  mod25;
    } date_t;

    // Divisible by 400 means divisible by 16 and by 25; divisible by 100
    // means divisible by 4 and by 25.
    function automatic logic leap_of(input logic [11:0] year, input logic [4:0] mod25);
        return (year[1:0] == 2'd0) && ((mod25 != 5'd0) || (year[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

[rtl/cdc_step.sv]
// One-day step unit of the calendar date counter: next day or previous day.
// Rolls over month and year ends and saturates at the year limits.
// Depends on cdc_pkg.
module cdc_step (
    input  cdc_pkg::date_t cur,
    input  logic           back,
    output cdc_pkg::date_t nxt
);

    logic [4:0] cur_len;
    logic [4:0] prev_len;
    logic [3:0] prev_month;
    logic       leap;

    assign leap       = cdc_pkg::leap_of(cur.year, cur.mod25);
    assign cur_len    = cdc_pkg::month_days(cur.month, leap);
    assign prev_month = cur.month - 4'd1;
    assign prev_len   = cdc_pkg::month_days(prev_month, leap);

    always_comb begin
        nxt = cur;
        if (!back) begin
            priority if (cur.day < cur_len) begin
                nxt.day = cur.day + 5'd1;
            end else if (cur.month < 4'd12) begin
                nxt.month = cur.month + 4'd1;
                nxt.day   = 5'd1;
            end else if (cur.year < cdc_pkg::YEAR_TOP) begin
                nxt.year  = cur.year + 12'd1;
                nxt.mod25 = (cur.mod25 == cdc_pkg::MOD25_LAST) ? 5'd0 : cur.mod25 + 5'd1;
                nxt.month = 4'd1;
                nxt.day   = 5'd1;
            end else begin
                // The date holds at the top limit.
                nxt = cur;
            end
        end else begin
            priority if (cur.day > 5'd1) begin
                nxt.day = cur.day - 5'd1;
            end else if (cur.month > 4'd1) begin
                nxt.month = prev_month;
                nxt.day   = prev_len;
            end else if (cur.year > 12'd0) begin
                nxt.year  = cur.year - 12'd1;
                nxt.mod25 = (cur.mod25 == 5'd0) ? cdc_pkg::MOD25_LAST : cur.mod25 - 5'd1;
                nxt.month = 4'd12;
                nxt.day   = 5'd31;
            end else begin
                // The date holds at the bottom limit.
                nxt = cur;
            end
        end
    end

endmodule

[rtl/calendar_date_counter.sv]
// Calendar date counter: next and previous day pass from the input transfer through the execute and
// finish states, set through execute, set-day and finish, and add N days through execute, the add loop
// (one day per cycle, stopping early at the top date) and finish. One item is in flight at a time; the
// next input transfer can be taken the cycle after the result is loaded into the output register.
// The add loop runs through the shared one-day step unit. Synchronous active-low reset sets
// the date to 1900-01-01 and empties the output register.
module calendar_date_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_new_day,
    input  logic [3:0]  s_new_month,
    input  logic [11:0] s_new_year,
    input  logic [15:0] s_day_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_cur_day,
    output logic [3:0]  m_cur_month,
    output logic [11:0] m_cur_year,
    output logic        m_is_leap
);

    // Only the low bits of the day count that the counter can hold are used.
    localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2,
        OP_ADD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SET_DAY,
        ST_ADD,
        ST_FINISH
    } state_t;

    // Year minus 1900 for a year known to lie in 1900..2100, taken modulo 25.
    // 1900 is itself a multiple of 25. The quotient is d*41/1024, exact for d up to 200.
    function automatic logic [4:0] mod25_of_set(input logic [7:0] d);
        logic [13:0] prod;
        logic [3:0]  q;
        logic [7:0]  q25;
        prod = {1'b0, d, 5'd0} + {3'd0, d, 3'd0} + {6'd0, d};
        q    = prod[13:10];
        q25  = {q, 4'd0} + {1'b0, q, 3'd0} + {4'd0, q};
        return 5'(d - q25);
    endfunction

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [5:0]     nday_reg, nday_next;
    logic [3:0]     nmonth_reg, nmonth_next;
    logic [11:0]    nyear_reg, nyear_next;
    logic [CNT_W-1:0] days_left_reg, days_left_next;
    cdc_pkg::date_t date_reg, date_next;
    logic           m_valid_reg, m_valid_next;
    logic [4:0]     out_day_reg, out_day_next;
    logic [3:0]     out_month_reg, out_month_next;
    logic [11:0]    out_year_reg, out_year_next;
    logic           out_leap_reg, out_leap_next;

    cdc_pkg::date_t stepped;
    logic           step_back;
    logic           cur_leap;
    logic           at_top;
    logic           year_ok;
    logic [11:0]    year_off;
    logic [4:0]     set_len;

    // The step unit moves backward only for a previous-day item; the add loop
    // and next-day item use it forward.
    assign step_back = (op_reg == OP_PREV);

    cdc_step u_step (
        .cur  (date_reg),
        .back (step_back),
        .nxt  (stepped)
    );

    assign cur_leap = cdc_pkg::leap_of(date_reg.year, date_reg.mod25);
    assign at_top   = (date_reg.year == cdc_pkg::YEAR_TOP) && (date_reg.month == 4'd12)
                   && (date_reg.day == 5'd31);
    assign year_ok  = (nyear_reg >= cdc_pkg::YEAR_MIN_SET) && (nyear_reg <= cdc_pkg::YEAR_MAX_SET);
    assign year_off = nyear_reg - cdc_pkg::YEAR_MIN_SET;
    // Month and year have already been validated when the day is checked.
    assign set_len  = cdc_pkg::month_days(date_reg.month, cur_leap);

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_cur_day   = out_day_reg;
    assign m_cur_month = out_month_reg;
    assign m_cur_year  = out_year_reg;
    assign m_is_leap   = out_leap_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        nday_next      = nday_reg;
        nmonth_next    = nmonth_reg;
        nyear_next     = nyear_reg;
        days_left_next = days_left_reg;
        date_next      = date_reg;
        m_valid_next   = m_valid_reg;
        out_day_next   = out_day_reg;
        out_month_next = out_month_reg;
        out_year_next  = out_year_reg;
        out_leap_next  = out_leap_reg;

        // The result register empties when the downstream side takes its transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next        = op_t'(s_operation);
                    nday_next      = s_new_day;
                    nmonth_next    = s_new_month;
                    nyear_next     = s_new_year;
                    days_left_next = s_day_count[CNT_W-1:0];
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (op_reg)
                    OP_SET: begin
                        date_next.month = ((nmonth_reg >= 4'd1) && (nmonth_reg <= 4'd12))
                                        ? nmonth_reg : 4'd1;
                        date_next.year  = year_ok ? nyear_reg : cdc_pkg::YEAR_MIN_SET;
                        date_next.mod25 = year_ok ? mod25_of_set(year_off[7:0]) : 5'd0;
                        state_next      = ST_SET_DAY;
                    end
                    OP_NEXT, OP_PREV: begin
                        date_next  = stepped;
                        state_next = ST_FINISH;
                    end
                    OP_ADD: begin
                        state_next = ST_ADD;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SET_DAY: begin
                date_next.day = ((nday_reg >= 6'd1) && (nday_reg <= {1'b0, set_len}))
                              ? nday_reg[4:0] : 5'd1;
                state_next    = ST_FINISH;
            end
            ST_ADD: begin
                // One day per cycle; the loop ends early once the top date is reached.
                if ((days_left_reg == '0) || at_top) begin
                    days_left_next = '0;
                    state_next     = ST_FINISH;
                end else begin
                    date_next      = stepped;
                    days_left_next = days_left_reg - CNT_W'(1);
                end
            end
            ST_FINISH: begin
                // Wait here until the result register is free for this transfer.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_day_next   = date_reg.day;
                    out_month_next = date_reg.month;
                    out_year_next  = date_reg.year;
                    out_leap_next  = cur_leap;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            days_left_reg  <= '0;
            date_reg.day   <= 5'd1;
            date_reg.month <= 4'd1;
            date_reg.year  <= cdc_pkg::YEAR_MIN_SET;
            date_reg.mod25 <= 5'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            days_left_reg <= days_left_next;
            date_reg      <= date_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg        <= op_next;
        nday_reg      <= nday_next;
        nmonth_reg    <= nmonth_next;
        nyear_reg     <= nyear_next;
        out_day_reg   <= out_day_next;
        out_month_reg <= out_month_next;
        out_year_reg  <= out_year_next;
        out_leap_reg  <= out_leap_next;
    end

    // An accepted item always occupies the sequencer in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("sequencer did not start after an input transfer");

    // The add loop leaves as soon as its count runs out.
    a_add_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ADD) && (days_left_reg == '0)) |=> (state_reg == ST_FINISH))
        else $error("add loop kept running with no days left");

    // Counting forward never lowers the year.
    a_add_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |=> (date_reg.year >= $past(date_reg.year)))
        else $error("year went backward during an add");

    // The held day is never zero, the month stays in 1..12 and the year modulo 25 stays in range.
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (date_reg.day >= 5'd1) && (date_reg.month >= 4'd1) && (date_reg.month <= 4'd12)
        && (date_reg.mod25 <= cdc_pkg::MOD25_LAST))
        else $error("held date out of range");

    // A result is only loaded when the previous one has left or is leaving.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(out_day_reg)
        && $stable(out_year_reg)))
        else $error("pending result was overwritten");

endmodule
